/* rtl/sidq_pkg.sv */
// Package for the sorted insert/drain queue.
// Item types, status codes and controller/datapath signal groups.
// No dependencies.
`timescale 1ns / 1ps

package sidq_pkg;

  localparam logic       REQ_INSERT  = 1'b0;
  localparam logic       REQ_DRAIN   = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_EMITTED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] sort_key;
    logic [15:0] item_tag;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_key;
    logic [15:0] out_tag;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       cap;       // latch incoming key and tag
    logic       cmp;       // compare new key against every cell
    logic       ins;       // shift cells right and insert
    logic       pop;       // move head into result, shift cells left
    logic       load_out;  // write result register
    logic [1:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic one;      // exactly one entry held
    logic out_free; // result register can take a new item this cycle
  } dp_stat_t;

endpackage

/* rtl/sidq_ctrl.sv */
// Controller FSM for the sorted insert/drain queue.
// Sequences compare, insert and drain steps; uses sidq_pkg.
`timescale 1ns / 1ps

module sidq_ctrl
  import sidq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_INS   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       fin;
  logic       in_fire;

  always_comb begin
    cmd = '0;
    fin = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        fin = 1'b0;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
      end
      S_INS: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.status   = stat.full ? ST_DROPPED : ST_INSERTED;
          cmd.ins      = !stat.full;
          fin          = 1'b1;
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.empty) begin
            cmd.status = ST_EMPTY;
            fin        = 1'b1;
          end else begin
            cmd.status = ST_EMITTED;
            cmd.pop    = 1'b1;
            fin        = stat.one;
          end
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    in_ready = (state_r == S_IDLE) || fin;
    in_fire  = in_valid && in_ready;
    cmd.cap  = in_fire;
  end

  always_comb begin
    state_nxt = state_r;
    priority if (in_fire) begin
      state_nxt = (in_req_type == REQ_DRAIN) ? S_DRAIN : S_CMP;
    end else if (fin) begin
      state_nxt = S_IDLE;
    end else if (state_r == S_CMP) begin
      state_nxt = S_INS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sidq_datapath.sv */
// Datapath for the sorted insert/drain queue: a row of shift cells,
// per-cell compare flags, entry count and the result register. Uses sidq_pkg.
`timescale 1ns / 1ps

module sidq_datapath
  import sidq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]      key_r [QUEUE_DEPTH];
  logic [15:0]      tag_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stay_r;   // cell keeps its place on insert
  logic [QUEUE_DEPTH-1:0] stay_nxt;
  logic [CW-1:0]    count_r;
  logic [15:0]      new_key_r, new_tag_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [QUEUE_DEPTH-1:0] vld, lt, gt;
  logic                   gt_any;

  // A cell stays if its key is below the new key; when no held key exceeds
  // the new key the insert appends after all equal keys.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      vld[i] = count_r > CW'(i);
      lt[i]  = key_r[i] < new_key_r;
      gt[i]  = vld[i] && (key_r[i] > new_key_r);
    end
    gt_any   = |gt;
    stay_nxt = vld & (lt | {QUEUE_DEPTH{!gt_any}});
  end

  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(QUEUE_DEPTH));
  assign stat.one      = (count_r == CW'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      new_key_r <= in_item.sort_key;
      new_tag_r <= in_item.item_tag;
    end
    if (cmd.cmp) begin
      stay_r <= stay_nxt;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic ins_here;
    if (g == 0) begin : g_head
      assign ins_here = 1'b1;
    end else begin : g_body
      assign ins_here = stay_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.ins && !stay_r[g]) begin
        if (ins_here) begin
          key_r[g] <= new_key_r;
          tag_r[g] <= new_tag_r;
        end else if (g > 0) begin
          key_r[g] <= key_r[(g > 0) ? g - 1 : 0];
          tag_r[g] <= tag_r[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.pop && (g < QUEUE_DEPTH - 1)) begin
        key_r[g] <= key_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        tag_r[g] <= tag_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.out_key <= cmd.pop ? key_r[0] : 16'd0;
      out_r.out_tag <= cmd.pop ? tag_r[0] : 16'd0;
      out_r.status  <= cmd.status;
      out_r.last    <= cmd.pop ? stat.one : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !stat.full && !cmd.pop)
    else $error("insert into full list or with pop");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty list");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result register overwritten while held");

endmodule

/* rtl/sorted_insert_drain_queue.sv */
// Top level of the sorted insert/drain queue.
// Joins sidq_ctrl and sidq_datapath; uses sidq_pkg.
//
// Usage:
//   in_valid/in_ready/in_item carry requests: req_type selects insert or
//   drain, sort_key and item_tag give the entry to insert.
//   out_valid/out_ready/out_item carry results: one per insert (inserted or
//   dropped because full), one per held entry on a drain in ascending key
//   order with last on the final one, or a single empty status when a drain
//   finds the list empty.
//   Insert: the compare step checks the new key against every cell, then
//   the insert step shifts the cells and writes the result; a new item is
//   accepted during the insert step, which waits while the result register
//   is still held.
//   Drain: one entry per cycle from the head cell while the result register
//   is free; the next item is accepted with the final entry.
//   The result register frees the block from the receiver: while out_ready
//   is low the held result stays and the block pauses before its next write.
//   Reset clears the entry count and the result valid; no clearing pass.
`timescale 1ns / 1ps

module sorted_insert_drain_queue
  import sidq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sidq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  sidq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
